// ===== hdl/rank_transform_top_assert.svh =====
// Assertion macros used by the RTL file of the rank transform datapath.
`ifndef RANK_TRANSFORM_TOP_ASSERT_SVH
`define RANK_TRANSFORM_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define RT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rank transform check failed");
`define RT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rank transform check failed");
`else
`define RT_ASSERT_SAME(label, clk, rst, ante, cons)
`define RT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/rt_pkg.sv =====
package rt_pkg;

   typedef struct packed {
      logic signed [31:0] value;
      logic               last_in;
   } rt_req_type;

   typedef struct packed {
      logic [3:0] rank;
      logic       last_out;
      logic       overflow;
   } rt_rsp_type;

   typedef enum logic [2:0] {
      STEP_WAIT,
      STEP_SETI,
      STEP_RDI,
      STEP_LATI,
      STEP_CMP,
      STEP_HOLD,
      STEP_EMIT,
      STEP_DONE
   } rt_step_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NOT_LAST,
      COND_J_MORE,
      COND_I_MORE,
      COND_OUT_BLOCKED
   } rt_cond_type;

   typedef struct packed {
      logic        take;
      logic        clr_i;
      logic        rd_en;
      logic        rd_sel_j;
      logic        lat_ki;
      logic        clr_j;
      logic        cmp_en;
      logic        emit;
      logic        clr_set;
      rt_cond_type cond;
      rt_step_type target;
   } rt_ctrl_type;

   typedef struct packed {
      logic last_taken;
      logic j_more;
      logic i_more;
      logic out_blocked;
   } rt_status_type;

   // Control store: one control word per step of the microprogram.
   function automatic rt_ctrl_type rt_rom(input rt_step_type step);
      rt_ctrl_type cw;
      cw = '0;
      cw.cond = COND_NEVER;
      cw.target = STEP_WAIT;
      unique case (step)
         STEP_WAIT: begin
            cw.take = 1'b1;
            cw.cond = COND_NOT_LAST;
            cw.target = STEP_WAIT;
         end
         STEP_SETI: begin
            cw.clr_i = 1'b1;
         end
         STEP_RDI: begin
            cw.rd_en = 1'b1;
            cw.clr_j = 1'b1;
         end
         STEP_LATI: begin
            cw.lat_ki = 1'b1;
            cw.rd_en = 1'b1;
            cw.rd_sel_j = 1'b1;
         end
         STEP_CMP: begin
            cw.cmp_en = 1'b1;
            cw.rd_en = 1'b1;
            cw.rd_sel_j = 1'b1;
            cw.cond = COND_J_MORE;
            cw.target = STEP_CMP;
         end
         STEP_HOLD: begin
            cw.cond = COND_OUT_BLOCKED;
            cw.target = STEP_HOLD;
         end
         STEP_EMIT: begin
            cw.emit = 1'b1;
            cw.cond = COND_I_MORE;
            cw.target = STEP_RDI;
         end
         STEP_DONE: begin
            cw.clr_set = 1'b1;
            cw.cond = COND_ALWAYS;
            cw.target = STEP_WAIT;
         end
         default: begin
            cw.cond = COND_ALWAYS;
            cw.target = STEP_WAIT;
         end
      endcase
      return cw;
   endfunction

endpackage

// ===== hdl/rt_sequencer.sv =====
module rt_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  rt_pkg::rt_status_type stat,
   output rt_pkg::rt_ctrl_type   ctrl
);

   rt_pkg::rt_step_type upc_ff;
   rt_pkg::rt_step_type upc_in;
   logic                jump;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= rt_pkg::STEP_WAIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

   always_comb begin
      ctrl = rt_pkg::rt_rom(upc_ff);
      unique case (ctrl.cond)
         rt_pkg::COND_NEVER:       jump = 1'b0;
         rt_pkg::COND_ALWAYS:      jump = 1'b1;
         rt_pkg::COND_NOT_LAST:    jump = !stat.last_taken;
         rt_pkg::COND_J_MORE:      jump = stat.j_more;
         rt_pkg::COND_I_MORE:      jump = stat.i_more;
         rt_pkg::COND_OUT_BLOCKED: jump = stat.out_blocked;
         default:                  jump = 1'b0;
      endcase
      if (jump) begin
         upc_in = ctrl.target;
      end else begin
         upc_in = rt_pkg::rt_step_type'(upc_ff + 3'd1);
      end
   end

endmodule

// ===== hdl/rt_datapath.sv =====
`include "rank_transform_top_assert.svh"

module rt_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  rt_pkg::rt_req_type    req_data,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output rt_pkg::rt_rsp_type    rsp_data,
   input  rt_pkg::rt_ctrl_type   ctrl,
   output rt_pkg::rt_status_type stat
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic signed [31:0] value_mem [CAPACITY];
   logic signed [31:0] rdata_ff;
   logic signed [31:0] ki_ff, ki_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               dropped_ff, dropped_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [CW-1:0]      j_ff, j_in;
   logic [CW-1:0]      jr_ff, jr_in;
   logic [3:0]         rank_ff, rank_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rt_pkg::rt_rsp_type rsp_data_ff, rsp_data_in;
   logic               accept;
   logic               full;
   logic               hit;
   logic [CW-1:0]      last_idx;
   logic [AW-1:0]      rd_addr;

   assign accept   = req_valid && ctrl.take;
   assign full     = (count_ff == CW'(CAPACITY));
   assign last_idx = count_ff - CW'(1);
   assign rd_addr  = ctrl.rd_sel_j ? j_ff[AW-1:0] : i_ff[AW-1:0];
   // Equal values rank the earlier arrival first.
   assign hit = (rdata_ff < ki_ff) || ((rdata_ff == ki_ff) && (jr_ff < i_ff));

   assign stat.last_taken  = accept && req_data.last_in;
   assign stat.j_more      = (jr_ff != last_idx);
   assign stat.i_more      = (i_ff != last_idx);
   assign stat.out_blocked = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      jr_in        = jr_ff;
      rank_in      = rank_ff;
      ki_in        = ki_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (ctrl.clr_set) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end else if (accept) begin
         if (!full) begin
            count_in = count_ff + CW'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end

      if (ctrl.clr_i) begin
         i_in = '0;
      end else if (ctrl.emit) begin
         i_in = i_ff + CW'(1);
      end

      if (ctrl.clr_j) begin
         j_in    = '0;
         rank_in = '0;
      end else begin
         if (ctrl.rd_en && ctrl.rd_sel_j) begin
            j_in  = j_ff + CW'(1);
            jr_in = j_ff;
         end
         if (ctrl.cmp_en && hit) begin
            rank_in = rank_ff + 4'd1;
         end
      end

      if (ctrl.lat_ki) begin
         ki_in = rdata_ff;
      end

      if (ctrl.emit) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.rank     = rank_ff;
         rsp_data_in.last_out = (i_ff == last_idx);
         rsp_data_in.overflow = dropped_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      jr_ff       <= jr_in;
      rank_ff     <= rank_in;
      ki_ff       <= ki_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (accept && !full) begin
         value_mem[count_ff[AW-1:0]] <= req_data.value;
      end
      if (ctrl.rd_en) begin
         rdata_ff <= value_mem[rd_addr];
      end
   end

   `RT_ASSERT_SAME(a_count_in_range, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `RT_ASSERT_SAME(a_emit_needs_room, clock, reset, ctrl.emit, !(rsp_valid_ff && rsp_stall))
   `RT_ASSERT_NEXT(a_set_cleared, clock, reset, ctrl.clr_set, (count_ff == '0) && !dropped_ff)
   `RT_ASSERT_SAME(a_drop_when_full, clock, reset, $rose(dropped_ff), full)

endmodule

// ===== hdl/rank_transform_top.sv =====
// Channel   Direction  Handshake             Item
// req_      in         req_valid/req_stall   rt_req_type (value, last_in)
// rsp_      out        rsp_valid/rsp_stall   rt_rsp_type (rank, last_out, overflow)
//
// Values are taken one per cycle until the item marked last; the value store
// has a single read port, which the compare loop sweeps once per emitted rank.
// Reset is synchronous and clears the step counter, fill count, drop flag and result valid.
// A stalled result holds the sequencer in its hold step; no item is taken
// while ranks are being produced.
module rank_transform_top #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  rt_pkg::rt_req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rt_pkg::rt_rsp_type rsp_data
);

   rt_pkg::rt_ctrl_type   ctrl;
   rt_pkg::rt_status_type stat;

   assign req_stall = !ctrl.take;

   rt_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   rt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .ctrl      (ctrl),
      .stat      (stat)
   );

endmodule
